### rtl/apr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Aging page replacement package
// Shared constants, sizes and the controller state type.
// ----------------------------------------------------------------------------
package apr_pkg;

    // Built capacity and page width defaults
    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 20;

    // Configuration register
    localparam int          CFG_W          = 5;
    localparam logic [4:0]  FRAMES_RST     = 5'd16;

    // Age byte
    localparam int          AGE_W          = 8;
    localparam logic [7:0]  AGE_NEW        = 8'h80;

    // Result field widths
    localparam int          SLOT_OUT_W     = 4;
    localparam int          COUNT_W        = 32;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_PUSH
    } t_state;

endpackage : apr_pkg
`default_nettype wire

### rtl/apr_frame_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame table memory
// One write port and one registered read port; holds page and age per slot.
// ----------------------------------------------------------------------------
module apr_frame_mem
    import apr_pkg::*;
#(
    parameter int DEPTH = MAX_FRAMES_DEF,
    parameter int WIDTH = PAGE_BITS_DEF + AGE_W,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule : apr_frame_mem
`default_nettype wire

### rtl/aging_page_replacement.sv
`default_nettype none
// A reference beat is taken only in idle; the next one waits until the result of
// the last has been handed to the output register. The single frame-table memory
// is walked one slot a cycle to age, match and find the oldest slot. A result may
// wait at the output while the next beat is taken.
// Reset (synchronous, active low) empties the table, clears the replacement
// count and sets frames_in_use to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Aging page replacement
// Approximate LRU over a frame table with 8-bit reference ages.
// ----------------------------------------------------------------------------
module aging_page_replacement
    import apr_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF,
    localparam int IN_W      = ((PAGE_BITS + 7) / 8) * 8,
    localparam int OUT_RAW_W = 1 + SLOT_OUT_W + 1 + PAGE_BITS + COUNT_W,
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // configuration
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,   // frames_in_use
    // reference stream
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,  // referenced page
    // result stream
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata   // hit, slot, evicted,
                                                 // evicted_page, replacement_count
);

    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SLW_W  = (IDX_W > SLOT_OUT_W) ? IDX_W : SLOT_OUT_W;
    localparam int ENT_W  = PAGE_BITS + AGE_W;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    t_state                 r_state, n_state;
    logic [CFG_W-1:0]       r_cfg;
    logic [CNT_W-1:0]       r_filled, n_filled;
    logic [COUNT_W-1:0]     r_total, n_total;
    logic [PAGE_BITS-1:0]   r_page, n_page;
    logic [CNT_W-1:0]       r_n, n_n;
    logic [CMP_W-1:0]       r_limit, n_limit;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_hit, n_hit;
    logic [IDX_W-1:0]       r_hit_slot, n_hit_slot;
    logic [AGE_W-1:0]       r_hit_age, n_hit_age;
    logic [IDX_W-1:0]       r_min_slot, n_min_slot;
    logic [AGE_W-1:0]       r_min_age, n_min_age;
    logic [PAGE_BITS-1:0]   r_min_page, n_min_page;
    logic [OUT_RAW_W-1:0]   r_res, n_res;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_RAW_W-1:0]   r_out_data, n_out_data;

    // Memory ports
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_wr_addr;
    logic [ENT_W-1:0]       mem_wr_data;
    logic [IDX_W-1:0]       mem_rd_addr;
    logic [ENT_W-1:0]       mem_rd_data;

    // Scan helpers
    logic [AGE_W-1:0]       rd_age_aged;
    logic [PAGE_BITS-1:0]   rd_page;
    logic                   scan_last;
    logic [CMP_W-1:0]       cfg_limit;
    logic [SLW_W-1:0]       res_slot_wide;
    logic                   res_hit;
    logic                   res_evicted;
    logic [PAGE_BITS-1:0]   res_evicted_page;
    logic [COUNT_W-1:0]     res_count;

    apr_frame_mem #(
        .DEPTH  (MAX_FRAMES),
        .WIDTH  (ENT_W),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign rd_page     = mem_rd_data[PAGE_BITS-1:0];
    assign rd_age_aged = mem_rd_data[ENT_W-1:PAGE_BITS] >> 1;
    assign scan_last   = (CNT_W'(r_idx) == (r_n - 1'b1));

    // Clamp the configured frame count to 1..MAX_FRAMES
    always_comb begin
        if (r_cfg == '0) begin
            cfg_limit = CMP_W'(1);
        end else if (CMP_W'(r_cfg) > CMP_W'(MAX_FRAMES)) begin
            cfg_limit = CMP_W'(MAX_FRAMES);
        end else begin
            cfg_limit = CMP_W'(r_cfg);
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= FRAMES_RST;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------------
    // Next state, memory access and result
    // ------------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_filled      = r_filled;
        n_total       = r_total;
        n_page        = r_page;
        n_n           = r_n;
        n_limit       = r_limit;
        n_idx         = r_idx;
        n_hit         = r_hit;
        n_hit_slot    = r_hit_slot;
        n_hit_age     = r_hit_age;
        n_min_slot    = r_min_slot;
        n_min_age     = r_min_age;
        n_min_page    = r_min_page;
        n_res         = r_res;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;

        mem_we        = 1'b0;
        mem_wr_addr   = r_idx;
        mem_wr_data   = {rd_age_aged, rd_page};
        mem_rd_addr   = r_idx + 1'b1;

        res_hit          = 1'b0;
        res_slot_wide    = '0;
        res_evicted      = 1'b0;
        res_evicted_page = '0;
        res_count        = r_total;

        s_axis_tready = (r_state == S_IDLE);

        // Drop the output beat once taken
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                mem_rd_addr = '0;
                if (s_axis_tvalid) begin
                    n_page  = s_axis_tdata[PAGE_BITS-1:0];
                    n_n     = r_filled;
                    n_limit = cfg_limit;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_state = (r_filled == '0) ? S_FINISH : S_SCAN;
                end
            end

            S_SCAN: begin
                // Age this slot and write it back
                mem_we = 1'b1;
                // Track first match
                if (!r_hit && rd_page == r_page) begin
                    n_hit      = 1'b1;
                    n_hit_slot = r_idx;
                    n_hit_age  = rd_age_aged;
                end
                // Track first smallest age
                if (r_idx == '0 || rd_age_aged < r_min_age) begin
                    n_min_slot = r_idx;
                    n_min_age  = rd_age_aged;
                    n_min_page = rd_page;
                end
                if (scan_last) begin
                    n_state = S_FINISH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_FINISH: begin
                mem_we = 1'b1;
                if (r_hit) begin
                    mem_wr_addr   = r_hit_slot;
                    mem_wr_data   = {r_hit_age | AGE_NEW, r_page};
                    res_hit       = 1'b1;
                    res_slot_wide = SLW_W'(r_hit_slot);
                end else if (CMP_W'(r_n) < r_limit) begin
                    // Fill the next empty slot
                    mem_wr_addr   = r_n[IDX_W-1:0];
                    mem_wr_data   = {AGE_NEW, r_page};
                    res_slot_wide = SLW_W'(r_n[IDX_W-1:0]);
                    n_filled      = r_n + 1'b1;
                end else begin
                    // Replace the oldest slot
                    mem_wr_addr      = r_min_slot;
                    mem_wr_data      = {AGE_NEW, r_page};
                    res_slot_wide    = SLW_W'(r_min_slot);
                    res_evicted      = 1'b1;
                    res_evicted_page = r_min_page;
                    res_count        = r_total + 1'b1;
                    n_total          = r_total + 1'b1;
                end
                n_res   = {res_count, res_evicted_page, res_evicted,
                           res_slot_wide[SLOT_OUT_W-1:0], res_hit};
                n_state = S_PUSH;
            end

            S_PUSH: begin
                // Hand the result to the output register when it is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_filled    <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_idx       <= '0;
            r_n         <= '0;
        end else begin
            r_state     <= n_state;
            r_filled    <= n_filled;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            r_hit       <= n_hit;
            r_idx       <= n_idx;
            r_n         <= n_n;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_page     <= n_page;
        r_limit    <= n_limit;
        r_hit_slot <= n_hit_slot;
        r_hit_age  <= n_hit_age;
        r_min_slot <= n_min_slot;
        r_min_age  <= n_min_age;
        r_min_page <= n_min_page;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_data);

endmodule : aging_page_replacement
`default_nettype wire

### verif/tb_aging_page_replacement.sv
// ----------------------------------------------------------------------------
// Aging page replacement testbench
// Sends page references over the input stream and checks every result beat
// against a cycle-free copy of the frame table held in a scoreboard class.
// Covers a short directed run, then random phases at many frame limits with
// both sides idling or stalling, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_aging_page_replacement;
    import apr_pkg::*;

    localparam int PAGE_W     = PAGE_BITS_DEF;
    localparam int IN_W       = ((PAGE_W + 7) / 8) * 8;
    localparam int OUT_RAW_W  = 1 + SLOT_OUT_W + 1 + PAGE_W + COUNT_W;
    localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int POOL_SIZE  = 32;
    localparam int CYCLE_CAP  = 600000;
    localparam int HOLD_LEN   = 400;

    // Result beat layout, hit in the lowest bit
    typedef struct packed {
        logic [OUT_W-OUT_RAW_W-1:0] pad;
        logic [COUNT_W-1:0]         replacement_count;
        logic [PAGE_W-1:0]          evicted_page;
        logic                       evicted;
        logic [SLOT_OUT_W-1:0]      slot;
        logic                       hit;
    } t_outcome;

    // Frame table copy, expected outcomes and the result check
    class t_frame_table_scoreboard;
        bit [PAGE_W-1:0]  frame_page [MAX_FRAMES_DEF];
        bit [AGE_W-1:0]   frame_age  [MAX_FRAMES_DEF];
        int unsigned      filled;
        bit [COUNT_W-1:0] replace_total;
        bit [CFG_W-1:0]   frames_cfg;
        t_outcome         pending_outcomes [$];
        int unsigned      mismatches;

        function new();
            foreach (frame_age[i]) begin
                frame_age[i]  = '0;
                frame_page[i] = '0;
            end
            filled        = 0;
            replace_total = '0;
            frames_cfg    = FRAMES_RST;
            mismatches    = 0;
        endfunction

        function void set_frames(bit [CFG_W-1:0] value);
            frames_cfg = value;
        endfunction

        function int outstanding();
            return pending_outcomes.size();
        endfunction

        // Age all filled frames, then resolve hit, fill or eviction
        function void note_reference(logic [PAGE_W-1:0] page);
            t_outcome    o;
            int unsigned lim;
            int unsigned n;
            int unsigned s;
            bit          found;
            lim   = (frames_cfg == 0) ? 1 : frames_cfg;
            if (lim > MAX_FRAMES_DEF) lim = MAX_FRAMES_DEF;
            n     = (filled > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : filled;
            o     = '0;
            found = 1'b0;
            s     = 0;
            for (int i = 0; i < n; i++) frame_age[i] = frame_age[i] >> 1;
            for (int i = 0; i < n; i++) begin
                if (!found && frame_page[i] == page) begin
                    found = 1'b1;
                    s     = i;
                end
            end
            if (found) begin
                frame_age[s] = frame_age[s] | AGE_NEW;
            end else if (n < lim) begin
                s             = n;
                frame_page[s] = page;
                frame_age[s]  = AGE_NEW;
                filled        = n + 1;
            end else begin
                // oldest frame, first in slot order on a tie
                s = 0;
                for (int i = 1; i < n; i++) begin
                    if (frame_age[i] < frame_age[s]) s = i;
                end
                o.evicted      = 1'b1;
                o.evicted_page = frame_page[s];
                frame_page[s]  = page;
                frame_age[s]   = AGE_NEW;
                replace_total  = replace_total + 1;
            end
            o.hit               = found;
            o.slot              = s[SLOT_OUT_W-1:0];
            o.replacement_count = replace_total;
            pending_outcomes.insert(pending_outcomes.size(), o);
        endfunction

        function void check_outcome(logic [OUT_W-1:0] data);
            t_outcome got;
            t_outcome want;
            got = data;
            if (pending_outcomes.size() == 0) begin
                $error("result beat with no reference waiting: %h", data);
                mismatches++;
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                mismatches++;
            end
            if (got.slot !== want.slot) begin
                $error("slot: expected %0d, got %0d", want.slot, got.slot);
                mismatches++;
            end
            if (got.evicted !== want.evicted) begin
                $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                mismatches++;
            end
            if (got.evicted_page !== want.evicted_page) begin
                $error("evicted_page: expected %h, got %h",
                       want.evicted_page, got.evicted_page);
                mismatches++;
            end
            if (got.replacement_count !== want.replacement_count) begin
                $error("replacement_count: expected %0d, got %0d",
                       want.replacement_count, got.replacement_count);
                mismatches++;
            end
        endfunction
    endclass

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata   = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;   // referenced page
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;         // hit, slot, evicted, evicted_page,
                                            // replacement_count

    t_frame_table_scoreboard frame_sb = new();

    int unsigned      tx_idle_pct   = 0;
    int unsigned      rx_idle_pct   = 0;
    int unsigned      hold_requests = 0;
    int unsigned      hold_served   = 0;
    int unsigned      hold_left     = 0;
    int unsigned      cycle_count   = 0;
    logic [PAGE_W-1:0] page_pool [POOL_SIZE];

    aging_page_replacement u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("aging_page_replacement test failed");
            $finish;
        end
    end

    // Watch both streams at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                frame_sb.note_reference(s_axis_tdata[PAGE_W-1:0]);
            if (m_axis_tvalid && m_axis_tready)
                frame_sb.check_outcome(m_axis_tdata);
        end
    end

    // Drive result-side ready; hold off for a long stretch on request
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_LEN;
        end
        if (hold_left != 0) begin
            hold_left     = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Offer one reference beat and hold it until taken
    task automatic send_page(input logic [PAGE_W-1:0] page);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_W'($urandom);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W-PAGE_W){1'b0}}, page};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every expected result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (frame_sb.outstanding() != 0) @(negedge i_clk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        drain_results();
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        frame_sb.set_frames(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly a working set drawn from the pool, with cold and corner pages
    task automatic run_phase(input int count, input int phase_id);
        int unsigned      ws;
        int unsigned      r;
        logic [PAGE_W-1:0] page;
        ws = $urandom_range(1, 24);
        for (int k = 0; k < count; k++) begin
            if (phase_id == 1 && k == 30) hold_requests = hold_requests + 1;
            if (phase_id == 4 && k == 60) drain_results();
            if ($urandom_range(0, 49) == 0)
                page_pool[$urandom_range(0, POOL_SIZE-1)] = PAGE_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < 78)
                page = page_pool[$urandom_range(0, ws-1)];
            else if (r < 90)
                page = PAGE_W'($urandom);
            else if (r < 95)
                page = page_pool[$urandom_range(0, POOL_SIZE-1)];
            else
                case ($urandom_range(0, 3))
                    0:       page = '0;
                    1:       page = '1;
                    2:       page = 20'hAAAAA;
                    default: page = 20'h55555;
                endcase
            send_page(page);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] phase_frames [9];
        phase_frames = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd17, 5'd8, 5'd5, 5'd16};
        foreach (page_pool[i]) page_pool[i] = PAGE_W'($urandom);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: small limit, fill, hit, evict oldest
        write_frames(5'd3);
        send_page(20'h00000);
        send_page(20'hFFFFF);
        send_page(20'hAAAAA);
        send_page(20'h00000);
        send_page(20'h55555);
        send_page(20'hFFFFF);
        send_page(20'h12345);
        send_page(20'h00000);

        // Limit of zero acts as one while three frames stay filled
        write_frames(5'd0);
        send_page(20'h55555);
        send_page(20'h0F0F0);
        send_page(20'hF0F0F);
        send_page(20'hAAAAA);

        // Limit above capacity saturates to full size
        write_frames(5'd31);
        send_page(20'h11111);
        send_page(20'h22222);
        send_page(20'h33333);
        send_page(20'h44444);
        send_page(20'hFFFFF);
        send_page(20'h00001);
        send_page(20'h80000);

        // Random phases across frame limits and idling modes
        for (int p = 0; p < 9; p++) begin
            write_frames(phase_frames[p]);
            if (p < 3) begin
                tx_idle_pct = 29;
                rx_idle_pct = 80;
            end else if (p < 6) begin
                tx_idle_pct = 80;
                rx_idle_pct = 29;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            run_phase(180, p);
        end

        drain_results();
        repeat (40) @(negedge i_clk);
        if (frame_sb.mismatches == 0 && frame_sb.outstanding() == 0) begin
            $display("aging_page_replacement test passed");
        end else begin
            $display("aging_page_replacement test failed");
        end
        $finish;
    end

endmodule
